[rtl/epf_pkg.sv]
// Package: shared types, codes and constants of the ellipse path flattener.
`timescale 1ns / 1ps

package epf_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned RADIUS_W  = 30;
  localparam int unsigned RINT_W    = RADIUS_W - FRAC_BITS;
  localparam int unsigned COUNT_W   = 13;

  localparam logic [17:0] PI_FIX  = 18'd205887;
  localparam logic [16:0] ONE_FIX = 17'd65536;

  localparam int unsigned DIV_NUM_W = 54;
  localparam int unsigned DIV_DEN_W = 41;

  localparam logic [DIV_NUM_W-1:0] PI_SQ    = DIV_NUM_W'(64'(PI_FIX) * 64'(PI_FIX));
  localparam logic [DIV_NUM_W-1:0] PI_CUBE  =
    DIV_NUM_W'(64'(PI_FIX) * 64'(PI_FIX) * 64'(PI_FIX));
  localparam logic [DIV_NUM_W-1:0] PI_TWICE = DIV_NUM_W'({PI_FIX, 1'b0});

  localparam int unsigned COEF_A_SHIFT = 15;
  localparam int unsigned COEF_B_SHIFT = 30;

  localparam logic [RINT_W-1:0] SEG_KNEE   = RINT_W'(90);
  localparam logic [RINT_W-1:0] SEG_LO_OFF = RINT_W'(16);
  localparam logic [RINT_W-1:0] SEG_HI_OFF = RINT_W'(92);
  localparam logic [16:0]       RECIP3     = 17'd43691;
  localparam int unsigned       RECIP3_SH  = 17;

  typedef enum logic [1:0] {
    CODE_MOVE  = 2'd0,
    CODE_LINE  = 2'd1,
    CODE_CLOSE = 2'd2,
    CODE_NONE  = 2'd3
  } path_code_e;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } opcode_e;

  typedef struct packed {
    logic                       opcode;
    logic signed [30:0]         center_x;
    logic signed [30:0]         center_y;
    logic        [RADIUS_W-1:0] radius_x;
    logic        [RADIUS_W-1:0] radius_y;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         path_code;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               last_of_path;
  } rsp_t;

  // Segment count from the integer part of one radius.
  function automatic logic [RINT_W-1:0] seg_count(input logic [RINT_W-1:0] ri);
    logic              low;
    logic [RINT_W-1:0] base;
    logic [RINT_W+16:0] prod;
    logic [RINT_W-1:0] quo;
    begin
      low  = (ri < SEG_KNEE);
      base = low ? {ri[RINT_W-3:0], 2'b00} : ri;
      prod = (RINT_W+17)'(base) * (RINT_W+17)'(RECIP3);
      quo  = prod[RECIP3_SH +: RINT_W];
      return low ? quo + SEG_LO_OFF : quo + SEG_HI_OFF;
    end
  endfunction

endpackage

[rtl/epf_if.sv]
// Interfaces: request and response channels of the ellipse path flattener.
`timescale 1ns / 1ps

interface epf_req_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [30:0] center_x;
  logic signed [30:0] center_y;
  logic        [29:0] radius_x;
  logic        [29:0] radius_y;

  modport source (output valid, opcode, center_x, center_y, radius_x, radius_y,
                  input ready);
  modport sink   (input valid, opcode, center_x, center_y, radius_x, radius_y,
                  output ready);
endinterface

interface epf_rsp_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  path_code;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               last_of_path;

  modport source (output valid, path_code, point_x, point_y, last_of_path,
                  input ready);
  modport sink   (input valid, path_code, point_x, point_y, last_of_path,
                  output ready);
endinterface

[rtl/ellipse_path_flattener.sv]
// Top level: ellipse path flattener, request queue feeding the point engine.
//
//   port    role    handshake      contents
//   req_i   sink    valid/ready    opcode, center_x, center_y, radius_x, radius_y
//   rsp_o   source  valid/ready    path_code, point_x, point_y, last_of_path
//
// A start is paced by three serial divisions, done one after another.
// A line step runs the rotation (ST_ROT1, ST_ROT2), then the radius scaling (ST_ROT3, ST_ROT4).
// Idle and close steps answer in the cycle after they leave the queue.
// Reset is asynchronous, active low, and leaves the block idle with no path.
// The request queue keeps taking requests while it has room, also while a response waits on rsp_o.
`timescale 1ns / 1ps

module ellipse_path_flattener import epf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  epf_req_if.sink   req_i,
  epf_rsp_if.source rsp_o
);

  logic head_valid, pop;
  cmd_t head;

  epf_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  epf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .rsp_o        (rsp_o)
  );

endmodule

[rtl/epf_front.sv]
// Front end: accepts requests and queues them for the back end.
`timescale 1ns / 1ps

module epf_front import epf_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  epf_req_if.sink    req_i,
  output logic       head_valid_o,
  output cmd_t       head_o,
  input  logic       pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;
  cmd_t             in_cmd;

  assign req_i.ready  = (cnt_q < CNT_W'(DEPTH));
  assign push         = req_i.valid && req_i.ready;
  assign pop          = pop_i && head_valid_o;
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  assign in_cmd.opcode   = req_i.opcode;
  assign in_cmd.center_x = req_i.center_x;
  assign in_cmd.center_y = req_i.center_y;
  assign in_cmd.radius_x = req_i.radius_x;
  assign in_cmd.radius_y = req_i.radius_y;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_cmd;
  end

endmodule

[rtl/epf_divider.sv]
// Divider: restoring unsigned division, one quotient bit per cycle.
`timescale 1ns / 1ps

module epf_divider #(
  parameter int unsigned NUM_W = 54,
  parameter int unsigned DEN_W = 41
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] work_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [DEN_W:0]   rem_sh, diff;
  logic             ge;

  assign rem_sh = {rem_q, work_q[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = !diff[DEN_W];
  assign done_o = done_q;
  assign quo_o  = work_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      work_q <= {work_q[NUM_W-2:0], ge};
    end
  end

endmodule

[rtl/epf_back.sv]
// Back end: coefficient setup, rotation recurrence and result register.
`timescale 1ns / 1ps

module epf_back import epf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  cmd_t      head_i,
  output logic      pop_o,
  epf_rsp_if.source rsp_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_NSQ   = 4'd1;
  localparam logic [3:0] ST_NCUBE = 4'd2;
  localparam logic [3:0] ST_DIV_A = 4'd3;
  localparam logic [3:0] ST_DIV_B = 4'd4;
  localparam logic [3:0] ST_DIV_C = 4'd5;
  localparam logic [3:0] ST_ROT1  = 4'd6;
  localparam logic [3:0] ST_ROT2  = 4'd7;
  localparam logic [3:0] ST_ROT3  = 4'd8;
  localparam logic [3:0] ST_ROT4  = 4'd9;

  logic [3:0]            state_q;
  logic                  active_q, rsp_valid_q;
  logic [COUNT_W-1:0]    steps_q, n_q;
  rsp_t                  rsp_q;

  logic signed [31:0]    cx_q, cy_q, ux_q, uy_q;
  logic [RADIUS_W-1:0]   rx_q, ry_q;
  logic [16:0]           a_q;
  logic [15:0]           b_q, b0_q;
  logic [25:0]           nsq_q;
  logic [DIV_DEN_W-1:0]  n3_q;
  logic signed [49:0]    ax_q, by_q, bx_q, ay_q;
  logic signed [62:0]    sx_q, sy_q;

  logic                  take;
  logic [RINT_W-1:0]     kx, ky;
  logic [RINT_W:0]       ksum;
  logic [38:0]           ncube;
  logic signed [50:0]    rot_x, rot_y;
  logic                  div_start, div_done;
  logic [DIV_NUM_W-1:0]  div_num, div_quo;
  logic [DIV_DEN_W-1:0]  div_den;

  assign take  = (state_q == ST_IDLE) && head_valid_i && !rsp_valid_q;
  assign pop_o = take;

  assign kx    = seg_count(head_i.radius_x[RADIUS_W-1:FRAC_BITS]);
  assign ky    = seg_count(head_i.radius_y[RADIUS_W-1:FRAC_BITS]);
  assign ksum  = {1'b0, kx} + {1'b0, ky};
  assign ncube = 39'(nsq_q) * 39'(n_q);
  assign rot_x = 51'(ax_q) - 51'(by_q);
  assign rot_y = 51'(bx_q) + 51'(ay_q);

  always_comb begin
    div_start = 1'b0;
    div_num   = PI_SQ;
    div_den   = DIV_DEN_W'(nsq_q);
    case (state_q)
      ST_NCUBE: div_start = 1'b1;
      ST_DIV_A: begin
        div_start = div_done;
        div_num   = PI_TWICE;
        div_den   = DIV_DEN_W'(n_q);
      end
      ST_DIV_B: begin
        div_start = div_done;
        div_num   = PI_CUBE;
        div_den   = n3_q;
      end
      default: ;
    endcase
  end

  epf_divider #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 1'b0;
      steps_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp_o.ready) rsp_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (take) begin
            if (head_i.opcode == OP_START) begin
              state_q <= ST_NSQ;
            end else if (!active_q) begin
              rsp_valid_q <= 1'b1;
            end else if (steps_q == '0) begin
              active_q    <= 1'b0;
              rsp_valid_q <= 1'b1;
            end else begin
              state_q <= ST_ROT1;
            end
          end
        end
        ST_NSQ:   state_q <= ST_NCUBE;
        ST_NCUBE: state_q <= ST_DIV_A;
        ST_DIV_A: if (div_done) state_q <= ST_DIV_B;
        ST_DIV_B: if (div_done) state_q <= ST_DIV_C;
        ST_DIV_C: begin
          if (div_done) begin
            active_q    <= 1'b1;
            steps_q     <= n_q;
            rsp_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_ROT1: state_q <= ST_ROT2;
        ST_ROT2: begin
          steps_q <= steps_q - 1'b1;
          state_q <= ST_ROT3;
        end
        ST_ROT3: state_q <= ST_ROT4;
        ST_ROT4: begin
          rsp_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (head_i.opcode == OP_START) begin
            cx_q <= 32'(head_i.center_x);
            cy_q <= 32'(head_i.center_y);
            rx_q <= head_i.radius_x;
            ry_q <= head_i.radius_y;
            n_q  <= ksum[COUNT_W:1];
          end else if (!active_q) begin
            rsp_q <= '{path_code: CODE_NONE, point_x: '0, point_y: '0, last_of_path: 1'b0};
          end else if (steps_q == '0) begin
            rsp_q <= '{path_code: CODE_CLOSE, point_x: '0, point_y: '0, last_of_path: 1'b1};
          end
        end
      end
      ST_NSQ:   nsq_q <= 26'(n_q) * 26'(n_q);
      ST_NCUBE: n3_q  <= 41'(ncube) + {1'b0, ncube, 1'b0};
      ST_DIV_A: if (div_done) a_q  <= ONE_FIX - 17'(div_quo >> COEF_A_SHIFT);
      ST_DIV_B: if (div_done) b0_q <= div_quo[15:0];
      ST_DIV_C: begin
        if (div_done) begin
          b_q   <= b0_q - 16'(div_quo >> COEF_B_SHIFT);
          ux_q  <= 32'(ONE_FIX);
          uy_q  <= '0;
          rsp_q <= '{path_code: CODE_MOVE, point_x: cx_q + {2'b00, rx_q},
                     point_y: cy_q, last_of_path: 1'b0};
        end
      end
      ST_ROT1: begin
        ax_q <= $signed({1'b0, a_q}) * ux_q;
        by_q <= $signed({1'b0, b_q}) * uy_q;
        bx_q <= $signed({1'b0, b_q}) * ux_q;
        ay_q <= $signed({1'b0, a_q}) * uy_q;
      end
      ST_ROT2: begin
        ux_q <= rot_x[FRAC_BITS +: 32];
        uy_q <= rot_y[FRAC_BITS +: 32];
      end
      ST_ROT3: begin
        sx_q <= $signed({1'b0, rx_q}) * ux_q;
        sy_q <= $signed({1'b0, ry_q}) * uy_q;
      end
      ST_ROT4: begin
        rsp_q <= '{path_code: CODE_LINE, point_x: cx_q + sx_q[FRAC_BITS +: 32],
                   point_y: cy_q + sy_q[FRAC_BITS +: 32], last_of_path: 1'b0};
      end
      default: ;
    endcase
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.path_code    = rsp_q.path_code;
  assign rsp_o.point_x      = rsp_q.point_x;
  assign rsp_o.point_y      = rsp_q.point_y;
  assign rsp_o.last_of_path = rsp_q.last_of_path;

endmodule

[tb/ellipse_path_flattener_test.sv]
// Testbench: checks the ellipse path flattener against a behavioral point predictor.
`timescale 1ns / 1ps

module ellipse_path_flattener_test;
  import epf_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  epf_req_if req_if ();
  epf_rsp_if rsp_if ();

  ellipse_path_flattener u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic signed [63:0] pr_cx, pr_cy, pr_rx, pr_ry, pr_a, pr_b, pr_ux, pr_uy;
  logic [12:0]        pr_left;
  logic               pr_active;

  rsp_t points_due[$];
  int   mismatches;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_cycles;

  function automatic logic signed [63:0] floor16(input logic signed [63:0] v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic logic [63:0] segs(input logic [63:0] ri);
    return ri < 90 ? (ri * 4) / 3 + 16 : ri / 3 + 92;
  endfunction

  function automatic rsp_t predict_point(input cmd_t c);
    rsp_t r;
    logic [63:0] n, pi, rx, ry;
    logic signed [63:0] nx, ny;
    r = '0;
    if (c.opcode == OP_START) begin
      rx = 64'(c.radius_x);
      ry = 64'(c.radius_y);
      n  = (segs(rx >> FRAC_BITS) + segs(ry >> FRAC_BITS)) >> 1;
      pi = 64'd205887;
      pr_a = 64'd65536 - (((pi * pi) / (n * n)) >> 15);
      pr_b = (pi * 2) / n - (((pi * pi * pi) / (3 * n * n * n)) >> 30);
      pr_cx = 64'(c.center_x);
      pr_cy = 64'(c.center_y);
      pr_rx = rx;
      pr_ry = ry;
      pr_ux = 64'd65536;
      pr_uy = 0;
      pr_left = n[12:0];
      pr_active = 1'b1;
      r.path_code = CODE_MOVE;
      r.point_x = 32'(pr_cx + pr_rx);
      r.point_y = 32'(pr_cy);
    end else if (!pr_active) begin
      r.path_code = CODE_NONE;
    end else if (pr_left == 0) begin
      pr_active = 1'b0;
      r.path_code = CODE_CLOSE;
      r.last_of_path = 1'b1;
    end else begin
      nx = floor16(pr_a * pr_ux - pr_b * pr_uy);
      ny = floor16(pr_b * pr_ux + pr_a * pr_uy);
      pr_ux = 64'(signed'(nx[31:0]));
      pr_uy = 64'(signed'(ny[31:0]));
      pr_left = pr_left - 1'b1;
      r.path_code = CODE_LINE;
      r.point_x = 32'(pr_cx + floor16(pr_ux * pr_rx));
      r.point_y = 32'(pr_cy + floor16(pr_uy * pr_ry));
    end
    return r;
  endfunction

  task automatic send_request(input cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.opcode   <= c.opcode;
    req_if.center_x <= c.center_x;
    req_if.center_y <= c.center_y;
    req_if.radius_x <= c.radius_x;
    req_if.radius_y <= c.radius_y;
    do @(posedge clk_i); while (!req_if.ready);
    points_due.push_back(predict_point(c));
    @(negedge clk_i);
  endtask

  task automatic drop_request();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_start(input logic [30:0] cx, input logic [30:0] cy,
                            input logic [29:0] rx, input logic [29:0] ry);
    cmd_t c;
    c = '{OP_START, cx, cy, rx, ry};
    send_request(c);
  endtask

  task automatic send_step();
    cmd_t c;
    c = '0;
    c.opcode = OP_STEP;
    c.center_x = 31'($urandom);
    c.center_y = 31'($urandom);
    c.radius_x = 30'($urandom);
    c.radius_y = 30'($urandom);
    send_request(c);
  endtask

  function automatic logic [29:0] pick_radius();
    case ($urandom_range(9))
      0: return 30'($urandom);
      1: return 30'(($urandom_range(400) << 16) | $urandom_range(65535));
      default: return 30'(($urandom_range(40) << 16) | $urandom_range(65535));
    endcase
  endfunction

  task automatic test_directed();
    send_step();
    send_start(31'h3FFF_FFFF, 31'h4000_0000, 30'h3FFF_FFFF, 30'h3FFF_FFFF);
    send_step();
    send_step();
    send_start(31'h4000_0000, 31'h3FFF_FFFF, 30'h0, 30'h0);
    repeat (18) send_step();
    send_step();
    send_start(31'h0, 31'h0, 30'h0005_8000, 30'h0059_0000);
    drop_request();
  endtask

  task automatic test_random_paths(input int items);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      send_start(31'($urandom), 31'($urandom), pick_radius(), pick_radius());
      len = ($urandom_range(9) < 7) ? 16 + $urandom_range(40) : $urandom_range(20);
      repeat (len) send_step();
      sent += len + 1;
    end
    drop_request();
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    send_start(31'h0001_0000, 31'h7FFF_0000, 30'h0010_0000, 30'h0002_0000);
    repeat (25) send_step();
    drop_request();
    wait (hold_cycles == 0);
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.opcode = 1'b0;
    req_if.center_x = '0;
    req_if.center_y = '0;
    req_if.radius_x = '0;
    req_if.radius_y = '0;
    pr_cx = 0; pr_cy = 0; pr_rx = 0; pr_ry = 0;
    pr_a = 0; pr_b = 0; pr_ux = 0; pr_uy = 0;
    pr_left = '0;
    pr_active = 1'b0;
    mismatches = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    send_idle_pct = 36;
    recv_idle_pct = 62;
    test_random_paths(500);
    send_idle_pct = 62;
    recv_idle_pct = 36;
    test_random_paths(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_paths(500);
    while (points_due.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    rsp_t got, want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.path_code, rsp_if.point_x, rsp_if.point_y, rsp_if.last_of_path};
      if (points_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected point %p", got);
      end else begin
        want = points_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  initial begin
    #80ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
